[sv/desr_pkg.sv]
// Shared types, DES tables and bit selection functions for the DES round block.
`timescale 1ns / 1ps
`default_nettype none

package desr_pkg;

  localparam logic [63:0] KEY_RESET = 64'h3030_3030_3030_3030;

  typedef struct packed {
    logic [31:0] right_half;
    logic [3:0]  round_index;
  } in_item_t;

  typedef struct packed {
    logic [31:0] f_value;
    logic [47:0] round_subkey;
  } out_item_t;

  // Positions count from 1 at the most significant bit.
  localparam logic [6:0] PC1_TAB [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39,
    7'd31, 7'd23, 7'd15, 7'd7,  7'd62, 7'd54, 7'd46, 7'd38,
    7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
    7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_TAB [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28,
    6'd15, 6'd6,  6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,
    6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40,
    6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
    6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  localparam logic [5:0] E_TAB [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
    6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
    6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
    6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
    6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] P_TAB [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  // Cumulative left rotation per round, modulo 28: the last round is a full turn.
  localparam logic [4:0] ROT_TAB [16] = '{
    5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
    5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd0
  };

  localparam logic [3:0] SBOX_TAB [8][64] = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
  };

  function automatic logic [55:0] pc1_sel(input logic [63:0] key);
    logic [55:0] res;
    for (int i = 0; i < 56; i++) begin
      res[55 - i] = key[6'(7'd64 - PC1_TAB[i])];
    end
    return res;
  endfunction

  function automatic logic [47:0] pc2_sel(input logic [55:0] cd);
    logic [47:0] res;
    for (int i = 0; i < 48; i++) begin
      res[47 - i] = cd[6'(6'd56 - PC2_TAB[i])];
    end
    return res;
  endfunction

  function automatic logic [47:0] e_expand(input logic [31:0] r);
    logic [47:0] res;
    for (int i = 0; i < 48; i++) begin
      res[47 - i] = r[5'(6'd32 - E_TAB[i])];
    end
    return res;
  endfunction

  function automatic logic [31:0] p_perm(input logic [31:0] s);
    logic [31:0] res;
    for (int i = 0; i < 32; i++) begin
      res[31 - i] = s[5'(6'd32 - P_TAB[i])];
    end
    return res;
  endfunction

  // Row from the outer two bits, column from the inner four.
  function automatic logic [3:0] sbox_lookup(input logic [2:0] box, input logic [5:0] chunk);
    return SBOX_TAB[box][{chunk[5], chunk[0], chunk[4:1]}];
  endfunction

endpackage

`default_nettype wire

[sv/desr_subkey.sv]
// Round subkey generation: PC1, cumulative rotation of C and D, PC2.
`timescale 1ns / 1ps
`default_nettype none

module desr_subkey
  import desr_pkg::*;
(
  input  wire logic [63:0] key_bits,
  input  wire logic [3:0]  round_index,
  output logic      [47:0] round_subkey
);

  logic [55:0] cd;
  logic [4:0]  rot_amt;
  logic [55:0] c_dbl;
  logic [55:0] d_dbl;
  logic [27:0] c_rot;
  logic [27:0] d_rot;

  assign cd      = pc1_sel(key_bits);
  assign rot_amt = ROT_TAB[round_index];

  // Rotate each half by shifting a doubled copy and keeping the top 28 bits.
  assign c_dbl = {cd[55:28], cd[55:28]} << rot_amt;
  assign d_dbl = {cd[27:0], cd[27:0]} << rot_amt;
  assign c_rot = c_dbl[55:28];
  assign d_rot = d_dbl[55:28];

  assign round_subkey = pc2_sel({c_rot, d_rot});

endmodule

`default_nettype wire

[sv/desr_feistel.sv]
// DES f function: E expansion, subkey mix, eight S-boxes and P permutation.
`timescale 1ns / 1ps
`default_nettype none

module desr_feistel
  import desr_pkg::*;
(
  input  wire logic [31:0] right_half,
  input  wire logic [47:0] round_subkey,
  output logic      [31:0] f_value
);

  logic [47:0] mixed;
  logic [31:0] s_out;

  assign mixed = e_expand(right_half) ^ round_subkey;

  for (genvar b = 0; b < 8; b++) begin : g_sbox
    assign s_out[31 - 4*b -: 4] = sbox_lookup(3'(b), mixed[47 - 6*b -: 6]);
  end

  assign f_value = p_perm(s_out);

endmodule

`default_nettype wire

[sv/des_round_with_key_schedule.sv]
// Top level of the DES round function with on-the-fly key schedule.
//
//   channel   ports                              handshake
//   input     start, busy, in_item               taken when start && !busy
//   result    out_valid, out_item                one-cycle strobe, no back-pressure
//   config    cfg_wr_en, cfg_wr_data             key written when cfg_wr_en
//
// A transaction is registered in in_r on acceptance, and its result is then registered
// in out_r and appears on out_item, strobed by out_valid. One transaction is taken
// every cycle; busy is held low. The subkey and f function are one pass of table
// logic between the input and result registers.
// Synchronous active-low reset clears the valid flags and loads the default key.
`timescale 1ns / 1ps
`default_nettype none

module des_round_with_key_schedule
  import desr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  output out_item_t        out_item,
  input  wire logic        cfg_wr_en,
  input  wire logic [63:0] cfg_wr_data
);

  logic [63:0] key_r,    key_nxt;
  logic        in_vld_r, in_vld_nxt;
  in_item_t    in_r,     in_nxt;
  logic        out_vld_r, out_vld_nxt;
  out_item_t   out_r,    out_nxt;
  logic [47:0] subkey;
  logic [31:0] f_val;
  logic        accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    key_nxt     = cfg_wr_en ? cfg_wr_data : key_r;
    in_vld_nxt  = accept;
    in_nxt      = accept ? in_item : in_r;
    out_vld_nxt = in_vld_r;
    out_nxt     = in_vld_r ? out_item_t'{f_value: f_val, round_subkey: subkey} : out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r     <= KEY_RESET;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      key_r     <= key_nxt;
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    in_r  <= in_nxt;
    out_r <= out_nxt;
  end

  desr_subkey u_subkey (
    .key_bits     (key_r),
    .round_index  (in_r.round_index),
    .round_subkey (subkey)
  );

  desr_feistel u_feistel (
    .right_half   (in_r.right_half),
    .round_subkey (subkey),
    .f_value      (f_val)
  );

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted transaction produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_vld_r))
    else $error("result strobe without a transaction in flight");

  a_key_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(cfg_wr_en) |-> key_r == $past(key_r))
    else $error("key register changed without a write");
`endif

endmodule

`default_nettype wire

[dv/des_round_with_key_schedule_tb.sv]
// Self-checking testbench for the DES round function with on-the-fly key schedule.
`timescale 1ns / 1ps

module des_round_with_key_schedule_tb;
  import desr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_PER_KEY = 140;
  localparam logic [63:0] POWER_ON_KEY = 64'h3030_3030_3030_3030;

  // Standard DES tables, positions counted from 1 at the MSB.
  localparam int PC1_POS [56] = '{
    57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
    60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
    29,21,13,5,28,20,12,4
  };
  localparam int PC2_POS [48] = '{
    14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
    41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32
  };
  localparam int E_POS [48] = '{
    32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
    16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1
  };
  localparam int P_POS [32] = '{
    16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25
  };
  // Cumulative left rotation of C and D for subkeys 1 to 16.
  localparam int ROT_TOTAL [16] = '{1,2,4,6,8,10,12,14,15,17,19,21,23,25,27,28};
  localparam int SBOXES [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
      0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
      15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
      3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
      13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
      13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
      1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
      13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
      3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
      14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
      11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
      10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
      4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
      13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
      6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
      1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
      2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}
  };

  logic        clk;
  logic        rst_n;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_wr_en;
  logic [63:0] cfg_wr_data;

  in_item_t    pending_q [$];
  out_item_t   expected_q [$];
  logic [63:0] key_now = POWER_ON_KEY;
  logic [63:0] key_plan [10];
  out_item_t   exp_item;
  bit          steady;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_cycles = 0;
  int          n_accepted = 0;
  int          n_results = 0;
  int          n_keys = 0;
  int          n_errors = 0;

  des_round_with_key_schedule dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [47:0] derive_subkey(input logic [63:0] key, input logic [3:0] rnd);
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    logic [47:0] k;
    int          amt;
    for (int i = 0; i < 56; i++) cd[55 - i] = key[64 - PC1_POS[i]];
    c   = cd[55:28];
    d   = cd[27:0];
    amt = ROT_TOTAL[rnd] % 28;
    // a full turn on the last round leaves both halves as they are
    if (amt != 0) begin
      c = (c << amt) | (c >> (28 - amt));
      d = (d << amt) | (d >> (28 - amt));
    end
    cd = {c, d};
    for (int i = 0; i < 48; i++) k[47 - i] = cd[56 - PC2_POS[i]];
    return k;
  endfunction

  function automatic logic [31:0] feistel_f(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] x;
    logic [31:0] s;
    logic [31:0] f;
    logic [5:0]  chunk;
    for (int i = 0; i < 48; i++) x[47 - i] = r[32 - E_POS[i]];
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      chunk = x[47 - 6 * i -: 6];
      s[31 - 4 * i -: 4] = 4'(SBOXES[i][{chunk[5], chunk[0], chunk[4:1]}]);
    end
    for (int i = 0; i < 32; i++) f[31 - i] = s[32 - P_POS[i]];
    return f;
  endfunction

  function automatic out_item_t predict_round(input logic [63:0] key, input in_item_t item);
    out_item_t res;
    res.round_subkey = derive_subkey(key, item.round_index);
    res.f_value      = feistel_f(item.right_half, res.round_subkey);
    return res;
  endfunction

  task automatic queue_item(input logic [31:0] r, input logic [3:0] rnd);
    in_item_t item;
    item.right_half  = r;
    item.round_index = rnd;
    pending_q.push_back(item);
  endtask

  // Hold until nothing is queued, in flight or expected, then let the pipe drain.
  task automatic wait_idle();
    do @(negedge clk); while (pending_q.size() != 0 || expected_q.size() != 0 || start);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_key(input logic [63:0] k);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= k;
    key_now      = k;
    @(posedge clk);
    // leave junk on the data bus: it must not land without the enable
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= {$urandom, $urandom};
    n_keys++;
  endtask

  // Driver: bursts of back-to-back transactions separated by random gaps, which may be zero.
  always @(posedge clk) begin
    if (!rst_n) begin
      start      <= 1'b0;
      burst_left  = 0;
      gap_left    = 0;
    end else begin
      if (start && !busy) begin
        expected_q.push_back(predict_round(key_now, in_item));
        n_accepted++;
      end
      if (start && busy) begin
        // hold the offered transaction
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (pending_q.size() != 0) begin
        in_item <= pending_q.pop_front();
        start   <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $error("unexpected result: f_value %h round_subkey %h",
               out_item.f_value, out_item.round_subkey);
        n_errors++;
      end else begin
        exp_item = expected_q.pop_front();
        if (out_item.f_value !== exp_item.f_value) begin
          $error("f_value: expected %h, got %h", exp_item.f_value, out_item.f_value);
          n_errors++;
        end
        if (out_item.round_subkey !== exp_item.round_subkey) begin
          $error("round_subkey: expected %h, got %h",
                 exp_item.round_subkey, out_item.round_subkey);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $error("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    steady      = 1'b0;

    // Sanity of the predictor against the textbook first-round example.
    if (derive_subkey(64'h1334_5779_9BBC_DFF1, 4'd0) !== 48'h1B02_EFFC_7072 ||
        feistel_f(32'hF0AA_F0AA, 48'h1B02_EFFC_7072) !== 32'h234A_A9BB) begin
      $error("predictor disagrees with the known first-round example");
      n_errors++;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: power-on key, extreme halves, every round including the last.
    queue_item(32'h0000_0000, 4'd0);
    queue_item(32'hFFFF_FFFF, 4'd15);
    queue_item(32'hFFFF_FFFF, 4'd0);
    queue_item(32'h0000_0000, 4'd15);
    queue_item(32'hAAAA_AAAA, 4'd7);
    queue_item(32'h5555_5555, 4'd8);
    for (int rnd = 0; rnd < 16; rnd++) queue_item($urandom, 4'(rnd));
    wait_idle();

    write_key(64'h1334_5779_9BBC_DFF1);
    queue_item(32'hF0AA_F0AA, 4'd0);
    queue_item(32'hF0AA_F0AA, 4'd15);
    wait_idle();

    key_plan[0] = 64'h0000_0000_0000_0000;
    key_plan[1] = 64'hFFFF_FFFF_FFFF_FFFF;
    key_plan[2] = 64'h0101_0101_0101_0101;
    key_plan[3] = 64'hAAAA_AAAA_AAAA_AAAA;
    key_plan[4] = 64'h5555_5555_5555_5555;
    for (int i = 5; i < 9; i++) key_plan[i] = {$urandom, $urandom};
    key_plan[9] = POWER_ON_KEY;

    for (int ph = 0; ph < 10; ph++) begin
      write_key(key_plan[ph]);
      steady = (ph % 3 == 0);
      for (int n = 0; n < RANDOM_PER_KEY; n++) begin
        case ($urandom_range(0, 15))
          0:       queue_item(32'h0000_0000, 4'($urandom_range(0, 15)));
          1:       queue_item(32'hFFFF_FFFF, 4'($urandom_range(0, 15)));
          default: queue_item($urandom, 4'($urandom_range(0, 15)));
        endcase
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d predicted results never arrived", expected_q.size());
      n_errors++;
    end
    $display("Covered %0d transactions and %0d results under %0d key writes plus power-on key,",
             n_accepted, n_results, n_keys);
    $display("all 16 rounds, extreme halves and keys, bursts with and without gaps.");
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[des_round_with_key_schedule.f]
sv/desr_pkg.sv
sv/desr_subkey.sv
sv/desr_feistel.sv
sv/des_round_with_key_schedule.sv
dv/des_round_with_key_schedule_tb.sv
